/* rtl/aes_pkg.sv */
package aes_pkg;

    localparam int RoundCount = 14;
    localparam int KeyWords = 8;
    localparam int TotalWords = 4 * (RoundCount + 1);

    typedef struct packed {
        logic        op;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_beat;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    localparam logic [1:0] RegKey0 = 2'd0;
    localparam logic [1:0] RegKey1 = 2'd1;
    localparam logic [1:0] RegKey2 = 2'd2;
    localparam logic [1:0] RegKey3 = 2'd3;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

/* rtl/aes_key_sched.sv */
module aes_key_sched #(
    parameter int ROUND_COUNT = aes_pkg::RoundCount
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [255:0]                   i_key,
    input  logic [$clog2(ROUND_COUNT+1)-1:0] i_rd_addr,
    output logic [127:0]                   o_rd_key,
    output logic                           o_busy
);
    import aes_pkg::*;

    localparam int AW = $clog2(ROUND_COUNT + 1);
    localparam int WC = 4 * (ROUND_COUNT + 1);
    localparam int WW = $clog2(WC + 1);

    // one key word per cycle into a sliding window of the last eight words
    logic [31:0]  r_win [8];
    logic [WW-1:0] r_idx;
    logic [7:0]   r_rcon;
    logic         r_run;
    logic [127:0] r_acc;
    logic [127:0] mem [ROUND_COUNT+1];
    logic [127:0] r_rd;

    logic [31:0] t_rot, n_word;
    always_comb begin
        t_rot = r_win[7];
        if (r_idx[2:0] == 3'd0)
            t_rot = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rcon, 24'h0};
        else if (r_idx[2:0] == 3'd4)
            t_rot = sub_word(r_win[7]);
        n_word = r_win[0] ^ t_rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int k = 0; k < 8; k++) r_win[k] <= i_key[255-32*k -: 32];
            r_idx  <= WW'(0);
            r_rcon <= 8'h01;
            r_run  <= 1'b1;
        end else if (r_run) begin
            logic [31:0] w;
            w = (r_idx < WW'(8)) ? r_win[r_idx[2:0]] : n_word;
            r_acc <= {r_acc[95:0], w};
            if (r_idx[1:0] == 2'd3)
                mem[AW'(r_idx >> 2)] <= {r_acc[95:0], w};
            if (r_idx >= WW'(8)) begin
                for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
                r_win[7] <= n_word;
                if (r_idx[2:0] == 3'd0) r_rcon <= xtime(r_rcon);
            end
            if (r_idx == WW'(WC - 1)) r_run <= 1'b0;
            r_idx <= r_idx + WW'(1);
        end
    end

    always_ff @(posedge i_clk) r_rd <= mem[i_rd_addr];

    assign o_rd_key = r_rd;
    assign o_busy   = r_run;
endmodule

/* rtl/aes_round.sv */
module aes_round (
    input  logic [127:0] i_state,
    input  logic         i_inv,
    input  logic         i_last,
    input  logic [127:0] i_key,
    output logic [127:0] o_state
);
    import aes_pkg::*;

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p, x;
        p = 8'h0; x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p ^= x;
            x = xtime(x);
        end
        return p;
    endfunction

    logic [7:0] s [16], t [16], m [16];
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = i_state[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (i_inv) t[r+4*((c+r)%4)] = ISBOX[s[r+4*c]];
                else       t[r+4*c]         = SBOX[s[r+4*((c+r)%4)]];
            end
        // forward: mix then key; inverse: key then mix
        if (i_inv) for (int i = 0; i < 16; i++) t[i] ^= i_key[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (i_inv)
                    m[4*c+r] = gm(t[4*c+r], 4'd14) ^ gm(t[4*c+(r+1)%4], 4'd11)
                             ^ gm(t[4*c+(r+2)%4], 4'd13) ^ gm(t[4*c+(r+3)%4], 4'd9);
                else
                    m[4*c+r] = gm(t[4*c+r], 4'd2) ^ gm(t[4*c+(r+1)%4], 4'd3)
                             ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
            end
        for (int i = 0; i < 16; i++) begin
            if (i_last)      o_state[127-8*i -: 8] = t[i] ^ (i_inv ? 8'h0 : i_key[127-8*i -: 8]);
            else if (i_inv)  o_state[127-8*i -: 8] = m[i];
            else             o_state[127-8*i -: 8] = m[i] ^ i_key[127-8*i -: 8];
        end
    end
endmodule

/* rtl/aes256_block_cipher_unit.sv */
// A start beat, once accepted, runs S_KEY0 and the S_RUN rounds before o_done;
// one block at a time, so a new start is taken once busy drops.
// Each round reads its key from the registered round-key memory ahead of use.
// A key write re-runs the schedule, one key word a cycle, with busy held high.
// Reset (synchronous, active low) clears the key to zero and expands it; results
// are strobed for one cycle and cannot be stalled.
module aes256_block_cipher_unit #(
    parameter int ROUND_COUNT = aes_pkg::RoundCount
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  aes_pkg::t_in_beat i_in,
    output logic              o_done,
    output aes_pkg::t_out_beat o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import aes_pkg::*;

    localparam int AW = $clog2(ROUND_COUNT + 1);

    typedef enum logic [1:0] {S_IDLE, S_KEY0, S_RUN} t_state;
    t_state       r_st;
    logic [63:0]  r_key [4];
    logic         r_restart;
    logic         r_inv;
    logic [AW-1:0] r_cnt, rd_addr;
    logic [127:0] r_blk, rk, nxt;
    logic         ks_busy;

    aes_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_restart(r_restart),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_rd_addr(rd_addr), .o_rd_key(rk), .o_busy(ks_busy)
    );

    // r_cnt counts rounds done; the key read is registered, so fetch two rounds ahead
    always_comb begin
        logic [AW-1:0] step;
        step = (r_st == S_RUN) ? r_cnt + AW'(2) : AW'(1);
        if (r_st == S_IDLE)
            rd_addr = i_in.op ? AW'(ROUND_COUNT) : AW'(0);
        else
            rd_addr = r_inv ? AW'(ROUND_COUNT) - step : step;
    end

    aes_round u_rnd (
        .i_state(r_blk), .i_inv(r_inv), .i_last(r_cnt == AW'(ROUND_COUNT - 1)),
        .i_key(rk), .o_state(nxt)
    );

    assign busy = (r_st != S_IDLE) || ks_busy || r_restart;

    always_ff @(posedge i_clk) begin
        r_restart <= i_rst_n && i_cfg_we;
        o_done    <= i_rst_n && (r_st == S_RUN) && (r_cnt == AW'(ROUND_COUNT - 1));
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= 64'h0;
            r_st <= S_IDLE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegKey0: r_key[0] <= i_cfg_data;
                    RegKey1: r_key[1] <= i_cfg_data;
                    RegKey2: r_key[2] <= i_cfg_data;
                    RegKey3: r_key[3] <= i_cfg_data;
                    default: r_key[0] <= r_key[0];
                endcase
            end
            case (r_st)
                S_IDLE: if (start && !busy) begin
                    r_inv <= i_in.op;
                    r_blk <= {i_in.block_high, i_in.block_low};
                    r_st  <= S_KEY0;
                end
                S_KEY0: begin
                    r_blk <= r_blk ^ rk;
                    r_cnt <= AW'(0);
                    r_st  <= S_RUN;
                end
                S_RUN: begin
                    r_blk <= nxt;
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(ROUND_COUNT - 1)) begin
                        o_out  <= nxt;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/aes_checker.sv */
module aes_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic i_cfg_we
);
    // an accepted beat makes the block busy
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept without busy");
    // done only while finishing
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("done while idle");
    // no back-to-back strobes
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double done");
    // a key write keeps the block busy
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy) else $error("key write not busy");
endmodule

bind aes256_block_cipher_unit aes_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .i_cfg_we(i_cfg_we)
);

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int WatchLimit = 2000;
    localparam int DrainCycles = 25;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in_beat   i_in = '0;
    logic       o_done;
    t_out_beat  o_out;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = RegKey0;
    logic [63:0] i_cfg_data = '0;

    aes256_block_cipher_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_done(o_done), .o_out(o_out), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // cipher model state
    logic [7:0]  sub_tab [256];
    logic [7:0]  inv_sub_tab [256];
    logic [63:0] key_word [4];
    logic [7:0]  round_key [15][16];

    t_out_beat   pending_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;
    t_out_beat   last_block = '0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        int         e;
        r = 8'h01;
        base = x;
        e = 254;
        while (e != 0) begin
            if (e & 1) r = gf_mul(r, base);
            base = gf_mul(base, base);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
        logic [15:0] d;
        d = {v, v} << n;
        return d[15:8];
    endfunction

    function automatic void build_sub_tables();
        logic [7:0] b;
        logic [7:0] s;
        for (int i = 0; i < 256; i++) begin
            b = gf_inv(i[7:0]);
            s = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
            sub_tab[i] = s;
            inv_sub_tab[s] = i[7:0];
        end
    endfunction

    function automatic void expand_key();
        logic [7:0] w [240];
        logic [7:0] t [4];
        logic [7:0] tmp;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 32; i++) w[i] = key_word[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = 8; i < 60; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[4 * (i - 1) + j];
            if (i % 8 == 0) begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int j = 0; j < 4; j++) t[j] = sub_tab[t[j]];
                t[0] ^= rc;
                rc = gf_mul(rc, 8'h02);
            end else if (i % 8 == 4) begin
                for (int j = 0; j < 4; j++) t[j] = sub_tab[t[j]];
            end
            for (int j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 8) + j] ^ t[j];
        end
        for (int r = 0; r < 15; r++)
            for (int j = 0; j < 16; j++) round_key[r][j] = w[16 * r + j];
    endfunction

    function automatic t_out_beat cipher_block(input t_in_beat b);
        logic [7:0] s [16];
        logic [7:0] o [16];
        logic [7:0] a [4];
        logic [7:0] fwd [4];
        logic [7:0] inv [4];
        logic [7:0] v;
        t_out_beat  res;
        fwd = '{8'd2, 8'd3, 8'd1, 8'd1};
        inv = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int i = 0; i < 8; i++) begin
            s[i] = b.block_high[63 - 8 * i -: 8];
            s[i + 8] = b.block_low[63 - 8 * i -: 8];
        end
        for (int step = 0; step <= 14; step++) begin
            if (b.op == OpEncrypt) begin
                if (step > 0) begin
                    for (int i = 0; i < 16; i++) s[i] = sub_tab[s[i]];
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) o[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
                    s = o;
                    if (step < 14)
                        for (int c = 0; c < 4; c++) begin
                            for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
                            for (int r = 0; r < 4; r++) begin
                                v = '0;
                                for (int k = 0; k < 4; k++) v ^= gf_mul(fwd[(k - r + 4) % 4], a[k]);
                                s[4 * c + r] = v;
                            end
                        end
                end
                for (int i = 0; i < 16; i++) s[i] ^= round_key[step][i];
            end else begin
                if (step > 0) begin
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) o[r + 4 * ((c + r) % 4)] = s[r + 4 * c];
                    s = o;
                    for (int i = 0; i < 16; i++) s[i] = inv_sub_tab[s[i]];
                end
                for (int i = 0; i < 16; i++) s[i] ^= round_key[14 - step][i];
                if (step > 0 && step < 14)
                    for (int c = 0; c < 4; c++) begin
                        for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
                        for (int r = 0; r < 4; r++) begin
                            v = '0;
                            for (int k = 0; k < 4; k++) v ^= gf_mul(inv[(k - r + 4) % 4], a[k]);
                            s[4 * c + r] = v;
                        end
                    end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.result_high[63 - 8 * i -: 8] = s[i];
            res.result_low[63 - 8 * i -: 8] = s[i + 8];
        end
        return res;
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // pick the direction of round trips from bit 1 of n so both ways are exercised
    function automatic logic pending_op(input int n);
        return n[1];
    endfunction

    // Drive one block; hold start high across back-to-back beats.
    task automatic send_block(input t_in_beat b, input bit typed, input t_out_beat want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (busy);
        last_block = cipher_block(b);
        pending_q.push_back(typed ? want : last_block);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] data);
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_word[idx] = data;
        expand_key();
    endtask

    typedef enum logic {RowBlock, RowKey} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [63:0] data;
        t_in_beat    blk;
        bit          typed;
        t_out_beat   want;
    } t_row;

    t_row directed [] = '{
        '{RowBlock, RegKey0, 0, '{OpEncrypt, 64'h0, 64'h0}, 1,
          '{64'hdc95c078a2408989, 64'had48a21492842087}},
        '{RowBlock, RegKey0, 0, '{OpDecrypt, 64'hdc95c078a2408989, 64'had48a21492842087}, 1,
          '{64'h0, 64'h0}},
        '{RowBlock, RegKey0, 0, '{OpEncrypt, '1, '1}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpDecrypt, '1, '1}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpEncrypt, 64'h8000000000000000, 64'h1}, 0, '{0, 0}},
        '{RowKey, RegKey0, 64'h0001020304050607, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        // partial key: only the first word written so far
        '{RowBlock, RegKey0, 0, '{OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff}, 0,
          '{0, 0}},
        '{RowKey, RegKey1, 64'h08090a0b0c0d0e0f, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowKey, RegKey2, 64'h1011121314151617, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowKey, RegKey3, 64'h18191a1b1c1d1e1f, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1,
          '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}},
        '{RowBlock, RegKey0, 0, '{OpDecrypt, 64'h8ea2b7ca516745bf, 64'heafc49904b496089}, 1,
          '{64'h0011223344556677, 64'h8899aabbccddeeff}},
        '{RowKey, RegKey0, '1, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowKey, RegKey1, '1, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowKey, RegKey2, '1, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowKey, RegKey3, '1, '{OpEncrypt, 0, 0}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpEncrypt, 64'h0, 64'h0}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpDecrypt, 64'h0, 64'h0}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpEncrypt, '1, '1}, 0, '{0, 0}},
        '{RowBlock, RegKey0, 0, '{OpDecrypt, '1, '1}, 0, '{0, 0}}
    };

    // check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_out.result_high !== want.result_high) begin
                    $display("%0t: result_high expected %h actual %h", $time,
                             want.result_high, o_out.result_high);
                    errors++;
                end
                if (o_out.result_low !== want.result_low) begin
                    $display("%0t: result_low expected %h actual %h", $time,
                             want.result_low, o_out.result_low);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("aes256_block_cipher_unit test failed");
            $finish;
        end
    end

    initial begin
        t_in_beat  b;
        t_out_beat none;
        int        sent;
        int        burst;
        none = '0;
        build_sub_tables();
        for (int i = 0; i < 4; i++) key_word[i] = '0;
        expand_key();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n]) begin
            if (directed[n].kind == RowKey) write_key(directed[n].idx, directed[n].data);
            else send_block(directed[n].blk, directed[n].typed, directed[n].want);
        end

        sent = 0;
        for (int phase = 0; sent < 950; phase++) begin
            // new key: all words at times, otherwise a random subset
            for (int k = 0; k < 4; k++)
                if (phase % 3 == 0 || $urandom_range(0, 2) == 0)
                    write_key(k[1:0], (phase == 4) ? '0 : (phase == 7) ? '1 : pick_word());
            burst = $urandom_range(40, 90);
            for (int n = 0; n < burst; n++) begin
                if (n % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    // round trip of the previous result
                    b.op = ~pending_op(n);
                    b.block_high = last_block.result_high;
                    b.block_low = last_block.result_low;
                end else begin
                    b.op = $urandom_range(0, 1) ? OpDecrypt : OpEncrypt;
                    b.block_high = pick_word();
                    b.block_low = pick_word();
                end
                send_block(b, 1'b0, none);
                sent++;
            end
        end

        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) $display("aes256_block_cipher_unit test passed");
        else $display("aes256_block_cipher_unit test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round.sv
rtl/aes256_block_cipher_unit.sv
rtl/aes_checker.sv
tb/sv/tb.sv
